FILE: sv/nflog_tlv_header_parser_core_assert.svh
// ----------------------------------------------------------------------------
// nflog tlv header parser assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef NFLOG_TLV_HEADER_PARSER_CORE_ASSERT_SVH
`define NFLOG_TLV_HEADER_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define NTLV_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ntlv assertion failed");

// next-cycle implication
`define NTLV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ntlv assertion failed");

`endif

FILE: sv/ntlv_pkg.sv
// ----------------------------------------------------------------------------
// ntlv_pkg
// types and constants shared by the nflog tlv header parser modules
// ----------------------------------------------------------------------------
`default_nettype none

package ntlv_pkg;

  // input item
  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } ntlv_in_t;

  // result item
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  protocol_family;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
  } ntlv_out_t;

  // position counter width, holds up to max packet length plus one
  localparam int unsigned POS_W = 17;

  // status codes
  localparam logic [2:0] ST_FOUND      = 3'd0;
  localparam logic [2:0] ST_TRUNC      = 3'd1;
  localparam logic [2:0] ST_VERSION    = 3'd2;
  localparam logic [2:0] ST_NO_PAYLOAD = 3'd3;
  localparam logic [2:0] ST_BAD_LEN    = 3'd4;
  localparam logic [2:0] ST_OVERSIZE   = 3'd5;
  localparam logic [2:0] ST_NONE       = 3'd7;

  // tlv type that marks the raw payload
  localparam logic [15:0] PAYLOAD_TYPE = 16'd9;

  // register select on paddr[2]
  localparam logic REG_TLV_BE = 1'b0;

endpackage

`default_nettype wire

FILE: sv/nflog_tlv_header_parser_core.sv
// ----------------------------------------------------------------------------
// nflog_tlv_header_parser_core
// streaming nflog link-layer header parser, one byte per cycle unless stalled, one result
// item per packet giving payload offset and length or an error status
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------
//  in      | into core | in_valid_i / in_stall_o   | packet_byte, last_byte
//  out     | from core | out_valid_o / out_stall_i | status, family, offset, len
//  cfg     | into core | apb psel/penable/pready   | tlv_big_endian at 0x0
//
//  one byte is accepted per cycle while in_stall_o is low; parse state updates at the accepting edge
//  the result item of a packet shows on out_valid_o in the cycle after its last
//  byte is accepted, from a single output register
//  in_stall_o is high only while that register holds an item that is stalled
//  reset clears all parse state, the byte order register and the output valid
//  no clearing pass: the core accepts items right after reset
// ----------------------------------------------------------------------------
`default_nettype none
`include "nflog_tlv_header_parser_core_assert.svh"

module nflog_tlv_header_parser_core #(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // byte input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire ntlv_pkg::ntlv_in_t in_item_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ntlv_pkg::ntlv_out_t     out_item_o,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);
  import ntlv_pkg::*;

  logic      tlv_be;
  logic      accept;
  logic      load;
  logic      out_full;
  ntlv_out_t result;

  // an item is taken whenever the output slot is not held by a stalled result
  assign in_stall_o = out_full;
  assign accept     = in_valid_i && !in_stall_o;

  // byte order register
  ntlv_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .tlv_be_o (tlv_be)
  );

  // per-byte parse and decision
  ntlv_parse #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .tlv_be_i (tlv_be),
    .load_o   (load),
    .result_o (result)
  );

  // result register
  ntlv_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .data_i      (result),
    .out_stall_i (out_stall_i),
    .full_o      (out_full),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  // a last byte taken always yields a result item next cycle
  `NTLV_ASSERT_NEXT(a_last_gives_result, accept && in_item_i.last_byte, out_valid_o)
  // stalling the input only happens with a result waiting
  `NTLV_ASSERT_SAME(a_stall_needs_result, in_stall_o, out_valid_o)
  // a found payload starts after the nflog header and one tlv header
  `NTLV_ASSERT_SAME(a_found_offset,
                    out_valid_o && (out_item_o.status == ST_FOUND),
                    out_item_o.payload_offset >= 16'd8)
  // error results carry no offset or length
  `NTLV_ASSERT_SAME(a_error_zero,
                    out_valid_o && (out_item_o.status != ST_FOUND),
                    (out_item_o.payload_offset == 16'd0) &&
                    (out_item_o.payload_length == 16'd0))

endmodule

`default_nettype wire

FILE: sv/ntlv_cfg_regs.sv
// ----------------------------------------------------------------------------
// ntlv_cfg_regs
// apb register file, holds the tlv byte order bit
// ----------------------------------------------------------------------------
`default_nettype none

module ntlv_cfg_regs (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic             tlv_be_o
);
  import ntlv_pkg::*;

  logic tlv_be_q, tlv_be_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TLV_BE);

  always_comb begin
    tlv_be_d = tlv_be_q;
    if (wr_en) begin
      tlv_be_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlv_be_q <= 1'b0;
    end else begin
      tlv_be_q <= tlv_be_d;
    end
  end

  // reads decode paddr[2] only; the low address bits are ignored
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_TLV_BE) begin
      prdata = {31'd0, tlv_be_q};
    end
  end

  assign tlv_be_o = tlv_be_q;

endmodule

`default_nettype wire

FILE: sv/ntlv_parse.sv
// ----------------------------------------------------------------------------
// ntlv_parse
// per-byte parse state and result decision for one packet
// ----------------------------------------------------------------------------
`default_nettype none

module ntlv_parse #(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire ntlv_pkg::ntlv_in_t item_i,
  input  wire logic              tlv_be_i,
  output logic                   load_o,
  output ntlv_pkg::ntlv_out_t    result_o
);
  import ntlv_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_TLV    = 2'd1,
    PH_SKIP   = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  localparam logic [POS_W-1:0] PosMax = POS_W'(MAX_PACKET_BYTES);
  localparam logic [POS_W-1:0] PosSat = POS_W'(MAX_PACKET_BYTES + 1);

  phase_e           phase_q, phase_n, phase_d;
  logic [POS_W-1:0] pos_q, pos_n, pos_d;
  logic [7:0]       family_q, family_n, family_d;
  logic             vbad_q, vbad_n, vbad_d;
  logic [2:0][7:0]  hdr_q, hdr_n, hdr_d;
  logic [15:0]      skip_q, skip_n, skip_d;
  logic [2:0]       latched_q, latched_n, latched_d;
  logic [15:0]      found_q, found_n, found_d;

  logic [7:0]       b;
  logic             last;
  logic [1:0]       slot;
  logic             tlv_go;
  logic [2:0]       st;
  logic [15:0]      tlv_len;
  logic [15:0]      tlv_kind;
  logic [16:0]      len_sum;
  logic [16:0]      skip_full;
  logic [2:0]       st_fin;

  assign b    = item_i.packet_byte;
  assign last = item_i.last_byte;
  assign slot = pos_q[1:0];

  // tlv header fields, byte 3 is the byte arriving now
  always_comb begin
    if (tlv_be_i) begin
      tlv_len  = {hdr_q[0], hdr_q[1]};
      tlv_kind = {hdr_q[2], b};
    end else begin
      tlv_len  = {hdr_q[1], hdr_q[0]};
      tlv_kind = {b, hdr_q[2]};
    end
    len_sum   = {1'b0, tlv_len} + 17'd3;
    // rounded length minus the header itself
    skip_full = {len_sum[16:2] - 15'd1, 2'b00};
  end

  // one byte step
  always_comb begin
    phase_n   = phase_q;
    pos_n     = pos_q;
    family_n  = family_q;
    vbad_n    = vbad_q;
    hdr_n     = hdr_q;
    skip_n    = skip_q;
    latched_n = latched_q;
    found_n   = found_q;
    st        = ST_NONE;
    tlv_go    = 1'b0;
    if (accept_i) begin
      if (pos_q < PosSat) begin
        pos_n = pos_q + POS_W'(1);
      end
      unique case (phase_q)
        PH_HEADER: begin
          if (pos_q < POS_W'(4)) begin
            if (pos_q == '0) begin
              family_n = b;
            end else if (pos_q == POS_W'(1)) begin
              vbad_n = (b != 8'd0);
            end
            if (last) begin
              st = ST_TRUNC;
            end
          end else if (vbad_q) begin
            latched_n = ST_VERSION;
            phase_n   = PH_DONE;
          end else begin
            phase_n = PH_TLV;
            tlv_go  = 1'b1;
          end
        end
        PH_TLV: begin
          tlv_go = 1'b1;
        end
        PH_SKIP: begin
          if (last) begin
            st = (skip_q > 16'd1) ? ST_BAD_LEN : ST_NO_PAYLOAD;
          end else begin
            skip_n = skip_q - 16'd1;
            if (skip_n == 16'd0) begin
              phase_n = PH_TLV;
            end
          end
        end
        PH_DONE: begin
          // bytes after a decision are only counted
        end
      endcase
      if (tlv_go) begin
        if (slot != 2'd3) begin
          hdr_n[slot] = b;
        end
        if (last) begin
          st = ST_NO_PAYLOAD;
        end else if (slot == 2'd3) begin
          if (tlv_kind == PAYLOAD_TYPE) begin
            found_n   = pos_q[15:0] + 16'd1;
            latched_n = ST_FOUND;
            phase_n   = PH_DONE;
          end else if (tlv_len < 16'd4) begin
            latched_n = ST_BAD_LEN;
            phase_n   = PH_DONE;
          end else begin
            skip_n = skip_full[15:0];
            if (skip_full != 17'd0) begin
              phase_n = PH_SKIP;
            end
          end
        end
      end
    end
  end

  // final decision and clear at packet end
  always_comb begin
    st_fin = st;
    if (st_fin == ST_NONE) begin
      st_fin = latched_n;
    end
    if (st_fin == ST_NONE) begin
      st_fin = ST_NO_PAYLOAD;
    end
    if (pos_n > PosMax) begin
      st_fin = ST_OVERSIZE;
    end

    load_o                   = accept_i && last;
    result_o.status          = st_fin;
    result_o.protocol_family = family_n;
    result_o.payload_offset  = 16'd0;
    result_o.payload_length  = 16'd0;
    if (st_fin == ST_FOUND) begin
      result_o.payload_offset = found_n;
      result_o.payload_length = pos_n[15:0] - found_n;
    end

    phase_d   = phase_n;
    pos_d     = pos_n;
    family_d  = family_n;
    vbad_d    = vbad_n;
    hdr_d     = hdr_n;
    skip_d    = skip_n;
    latched_d = latched_n;
    found_d   = found_n;
    if (accept_i && last) begin
      phase_d   = PH_HEADER;
      pos_d     = '0;
      family_d  = 8'd0;
      vbad_d    = 1'b0;
      hdr_d     = '0;
      skip_d    = 16'd0;
      latched_d = ST_NONE;
      found_d   = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      pos_q     <= '0;
      family_q  <= 8'd0;
      vbad_q    <= 1'b0;
      hdr_q     <= '0;
      skip_q    <= 16'd0;
      latched_q <= ST_NONE;
      found_q   <= 16'd0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      family_q  <= family_d;
      vbad_q    <= vbad_d;
      hdr_q     <= hdr_d;
      skip_q    <= skip_d;
      latched_q <= latched_d;
      found_q   <= found_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ntlv_out_reg.sv
// ----------------------------------------------------------------------------
// ntlv_out_reg
// result register on the output channel
// ----------------------------------------------------------------------------
`default_nettype none

module ntlv_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire ntlv_pkg::ntlv_out_t data_i,
  input  wire logic               out_stall_i,
  output logic                    full_o,
  output logic                    out_valid_o,
  output ntlv_pkg::ntlv_out_t     out_item_o
);
  import ntlv_pkg::*;

  logic      valid_q, valid_d;
  ntlv_out_t data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = data_i;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // full and held: the slot cannot take a new result this cycle
  assign full_o      = valid_q && out_stall_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = data_q;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nflog tlv header parser testbench
// streams nflog packets byte by byte into the parser core, predicts each
// packet's result item with a behavioral parser and compares every field;
// directed packets, then random packets under several traffic patterns and
// both tlv byte orders
// ----------------------------------------------------------------------------
module testbench;
  import ntlv_pkg::*;

  localparam int unsigned MAX_PACKET_BYTES = 65535;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned HOLD_CYCLES      = 300;
  localparam int unsigned RANDOM_BYTES     = 180;   // per traffic phase
  localparam logic [2:0]  ADDR_TLV_BE      = {REG_TLV_BE, 2'b00};

  typedef enum logic [1:0] {PH_HEADER, PH_TLV, PH_SKIP, PH_DONE} parse_phase_e;
  typedef enum int {
    MODE_STEADY, MODE_SEND_GAPS, MODE_RECV_STALLS, MODE_BOTH, MODE_LONG_HOLD
  } traffic_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  ntlv_in_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  ntlv_out_t   out_item_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  nflog_tlv_header_parser_core #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // bytes waiting to be offered, and verdicts waiting for their result item
  ntlv_in_t      packet_bytes[$];
  ntlv_out_t     pending_verdicts[$];
  logic [7:0]    pkt_buf[$];
  traffic_mode_e traffic     = MODE_STEADY;
  int unsigned   hold_count  = 0;
  int unsigned   cycle_count = 0;
  int            errors      = 0;

  // parser state as the block should hold it
  logic [16:0]   pos_count;
  parse_phase_e  phase;
  logic [7:0]    family;
  logic          version_bad;
  logic [31:0]   tlv_bytes;
  logic [16:0]   skip_left;
  logic [2:0]    verdict;
  logic [15:0]   payload_start;
  logic          big_endian = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // behavioral parser
  // ---------------------------------------------------------------------------
  function automatic void clear_packet_state();
    pos_count     = '0;
    phase         = PH_HEADER;
    family        = '0;
    version_bad   = 1'b0;
    tlv_bytes     = '0;
    skip_left     = '0;
    verdict       = ST_NONE;
    payload_start = '0;
  endfunction

  // one byte of a tlv header; a status only when the packet ends here
  function automatic logic [2:0] tlv_header_byte(logic [16:0] pos, logic [7:0] b,
                                                 logic last);
    logic [1:0]  slot;
    logic [15:0] len;
    logic [15:0] typ;
    logic [16:0] rounded;
    slot = pos[1:0];
    tlv_bytes[8*int'(slot) +: 8] = b;
    if (last) return ST_NO_PAYLOAD;
    if (slot != 2'd3) return ST_NONE;
    if (big_endian) begin
      len = {tlv_bytes[7:0], tlv_bytes[15:8]};
      typ = {tlv_bytes[23:16], tlv_bytes[31:24]};
    end else begin
      len = tlv_bytes[15:0];
      typ = tlv_bytes[31:16];
    end
    // payload type wins even over a short length
    if (typ == PAYLOAD_TYPE) begin
      payload_start = pos[15:0] + 16'd1;
      verdict       = ST_FOUND;
      phase         = PH_DONE;
    end else if (len < 16'd4) begin
      verdict = ST_BAD_LEN;
      phase   = PH_DONE;
    end else begin
      rounded   = ({1'b0, len} + 17'd3) & ~17'd3;
      skip_left = rounded - 17'd4;
      if (skip_left != '0) phase = PH_SKIP;
    end
    return ST_NONE;
  endfunction

  // advance the parser by one accepted byte, queue a verdict on the last one
  function automatic void parse_nflog_byte(ntlv_in_t item);
    logic [16:0] pos;
    logic [16:0] count;
    logic [2:0]  st;
    ntlv_out_t   res;
    pos = pos_count;
    st  = ST_NONE;
    if (pos_count < 17'(MAX_PACKET_BYTES + 1)) pos_count++;
    count = pos_count;
    case (phase)
      PH_HEADER: begin
        if (pos < 17'd4) begin
          if (pos == 17'd0) family = item.packet_byte;
          else if (pos == 17'd1) version_bad = (item.packet_byte != 8'd0);
          if (item.last_byte) st = ST_TRUNC;
        end else if (version_bad) begin
          verdict = ST_VERSION;
          phase   = PH_DONE;
        end else begin
          phase = PH_TLV;
          st    = tlv_header_byte(pos, item.packet_byte, item.last_byte);
        end
      end
      PH_TLV: st = tlv_header_byte(pos, item.packet_byte, item.last_byte);
      PH_SKIP: begin
        if (item.last_byte) begin
          st = (skip_left > 17'd1) ? ST_BAD_LEN : ST_NO_PAYLOAD;
        end else begin
          skip_left--;
          if (skip_left == '0) phase = PH_TLV;
        end
      end
      default: ;
    endcase
    if (!item.last_byte) return;
    if (st == ST_NONE) st = verdict;
    if (st == ST_NONE) st = ST_NO_PAYLOAD;
    if (count > 17'(MAX_PACKET_BYTES)) st = ST_OVERSIZE;
    res.status          = st;
    res.protocol_family = family;
    res.payload_offset  = (st == ST_FOUND) ? payload_start : 16'd0;
    res.payload_length  = (st == ST_FOUND) ? count[15:0] - payload_start : 16'd0;
    pending_verdicts.push_back(res);
    clear_packet_state();
  endfunction

  // ---------------------------------------------------------------------------
  // packet building
  // ---------------------------------------------------------------------------
  function automatic void put_bytes(int unsigned n);
    repeat (n) pkt_buf.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void put_header(logic [7:0] fam, logic [7:0] ver);
    pkt_buf.push_back(fam);
    pkt_buf.push_back(ver);
    put_bytes(2);
  endfunction

  // tlv header in the byte order currently programmed
  function automatic void put_tlv(logic [15:0] len, logic [15:0] typ);
    if (big_endian) begin
      pkt_buf.push_back(len[15:8]);
      pkt_buf.push_back(len[7:0]);
      pkt_buf.push_back(typ[15:8]);
      pkt_buf.push_back(typ[7:0]);
    end else begin
      pkt_buf.push_back(len[7:0]);
      pkt_buf.push_back(len[15:8]);
      pkt_buf.push_back(typ[7:0]);
      pkt_buf.push_back(typ[15:8]);
    end
  endfunction

  function automatic void trim_to(int unsigned n);
    while (pkt_buf.size() > n) void'(pkt_buf.pop_back());
  endfunction

  function automatic void send_packet();
    ntlv_in_t item;
    foreach (pkt_buf[i]) begin
      item.packet_byte = pkt_buf[i];
      item.last_byte   = (i == pkt_buf.size() - 1);
      packet_bytes.push_back(item);
    end
    pkt_buf.delete();
  endfunction

  // a tlv type that is not the payload type, often a small one
  function automatic logic [15:0] other_type();
    logic [15:0] t;
    t = $urandom_range(1) ? 16'($urandom_range(65535)) : 16'($urandom_range(16));
    if (t == PAYLOAD_TYPE) t = PAYLOAD_TYPE + 16'd1;
    return t;
  endfunction

  function automatic void directed_packets();
    // one to four bytes: truncated header, whatever the version byte says
    for (int n = 1; n <= 4; n++) begin
      put_header(8'hFF, 8'hFF);
      trim_to(n);
      send_packet();
    end
    // nonzero version, decided on the fifth byte
    put_header(8'h00, 8'h80);
    put_bytes(1);
    send_packet();
    // version zero but the packet ends where the first tlv starts
    put_header(8'h00, 8'h00);
    put_bytes(1);
    send_packet();
    // payload tlv header completes on the last byte: still no payload
    put_header(8'h02, 8'h00);
    put_tlv(16'd0, PAYLOAD_TYPE);
    send_packet();
    // payload tlv with a length below four, one payload byte
    put_header(8'hFF, 8'h00);
    put_tlv(16'd0, PAYLOAD_TYPE);
    put_bytes(1);
    send_packet();
    // length below four on another type
    put_header(8'h0A, 8'h00);
    put_tlv(16'd3, 16'd1);
    put_bytes(2);
    send_packet();
    // length five rounds up to eight, then the payload
    put_header(8'h0A, 8'h00);
    put_tlv(16'd5, 16'hFFFF);
    put_bytes(4);
    put_tlv(16'hFFFF, PAYLOAD_TYPE);
    put_bytes(3);
    send_packet();
    // tlv ends exactly at the packet end
    put_header(8'h02, 8'h00);
    put_tlv(16'd8, 16'd3);
    put_bytes(4);
    send_packet();
    // tlv longer than what is left
    put_header(8'h02, 8'h00);
    put_tlv(16'd12, 16'd3);
    put_bytes(4);
    send_packet();
    // bad length, then bytes after the decision
    put_header(8'h02, 8'h00);
    put_tlv(16'd2, 16'hFFFE);
    put_bytes(9);
    send_packet();
    // raw tlv bytes: length 4 and payload type only when read big-endian
    pkt_buf = '{8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 8'h00, 8'h09};
    put_bytes(4);
    send_packet();
    // nonzero version on a longer packet
    put_header(8'h18, 8'h01);
    put_bytes(12);
    send_packet();
  endfunction

  // mostly well-formed tlv chains with random content, some noise and breakage
  function automatic void build_random_packet();
    int unsigned kind;
    int unsigned ending;
    int unsigned len;
    kind = $urandom_range(99);
    if (kind < 10) begin
      put_bytes($urandom_range(1, 40));
    end else if (kind < 18) begin
      put_header(8'($urandom_range(255)), $urandom_range(1) ? 8'($urandom_range(255)) : 8'd0);
      put_bytes(2);
      trim_to($urandom_range(1, 6));
    end else begin
      put_header(8'($urandom_range(255)),
                 ($urandom_range(9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0);
      repeat ($urandom_range(0, 3)) begin
        len = $urandom_range(4, 24);
        put_tlv(16'(len), other_type());
        put_bytes(((len + 3) & ~32'd3) - 4);
      end
      ending = $urandom_range(99);
      if (ending < 70) begin
        put_tlv(16'($urandom_range(65535)), PAYLOAD_TYPE);
        put_bytes($urandom_range(1, 24));
      end else if (ending < 78) begin
        put_tlv(16'($urandom_range(3)), other_type());
        put_bytes($urandom_range(0, 6));
      end else if (ending < 86) begin
        len = $urandom_range(16, 400);
        put_tlv(16'(len), other_type());
        put_bytes($urandom_range(0, len / 2));
      end else if (ending >= 93) begin
        trim_to($urandom_range(1, pkt_buf.size()));
      end
      // otherwise the packet ends exactly at the end of the last tlv
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offers queued bytes, predicts each byte at its acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    int unsigned gap_pct;
    gap_pct = (traffic == MODE_SEND_GAPS) ? 65 : (traffic == MODE_BOTH) ? 32 : 0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) parse_nflog_byte(in_item_i);
      // a shown item stays until taken
      if (!in_valid_i || !in_stall_o) begin
        if (packet_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
          in_valid_i <= 1'b1;
          in_item_i  <= packet_bytes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall; in the long hold phase it first holds off for a long
  // stretch so the output register fills and the input stalls
  always @(posedge clk_i) begin
    int unsigned stall_pct;
    stall_pct = (traffic == MODE_RECV_STALLS) ? 65 : (traffic == MODE_BOTH) ? 32 : 0;
    if (rst_ni) begin
      if (traffic == MODE_LONG_HOLD && hold_count < HOLD_CYCLES) begin
        out_stall_i <= 1'b1;
        hold_count  <= hold_count + 1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic report_error(string msg);
    errors++;
    if (errors <= 100) $display("[%0t] error: %s", $time, msg);
  endtask

  // result checker
  always @(posedge clk_i) begin
    ntlv_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        report_error($sformatf("result item with no packet outstanding: %h", out_item_o));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_item_o.status !== want.status)
          report_error($sformatf("status %0d, expected %0d",
                                 out_item_o.status, want.status));
        if (out_item_o.protocol_family !== want.protocol_family)
          report_error($sformatf("protocol_family %h, expected %h",
                                 out_item_o.protocol_family, want.protocol_family));
        if (out_item_o.payload_offset !== want.payload_offset)
          report_error($sformatf("payload_offset %0d, expected %0d",
                                 out_item_o.payload_offset, want.payload_offset));
        if (out_item_o.payload_length !== want.payload_length)
          report_error($sformatf("payload_length %0d, expected %0d",
                                 out_item_o.payload_length, want.payload_length));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // phase control
  // ---------------------------------------------------------------------------
  // sender pauses here until every verdict has come, then idles for the DRAIN_CYCLES drain
  task automatic wait_drained();
    while (packet_bytes.size() != 0 || in_valid_i || pending_verdicts.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // register write: setup cycle, then access cycle
  task automatic set_byte_order(logic be);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TLV_BE;
    pwdata  <= {31'd0, be};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    big_endian = be;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned queued;
    rst_ni = 1'b0;
    clear_packet_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed packets in both byte orders
    set_byte_order(1'b0);
    directed_packets();
    wait_drained();
    set_byte_order(1'b1);
    directed_packets();
    wait_drained();

    // random packets, one phase per traffic pattern, byte order alternating
    for (int i = 0; i < 5; i++) begin
      set_byte_order(i[0]);
      traffic = traffic_mode_e'(i);
      queued  = 0;
      while (queued < RANDOM_BYTES) begin
        build_random_packet();
        queued += pkt_buf.size();
        send_packet();
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
